[rtl/ptes_pkg.sv]
// Shared types and constants of the priority timer event scheduler.
// No dependencies; used by ptes_front, ptes_back and the top level.
package ptes_pkg;

	localparam int EVENT_SLOTS = 16;
	localparam int SLOT_W      = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic CMD_CREATE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef enum logic [2:0] {
		KIND_NOP    = 3'b001,
		KIND_CREATE = 3'b010,
		KIND_TICK   = 3'b100
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [31:0]        now_ms;
		logic [15:0]        event_handle;
		logic [31:0]        interval_ms;
		logic signed [15:0] repeat_count;
		logic signed [15:0] priority_req;
	} item_t;

	typedef struct packed {
		logic        fired;
		logic [15:0] fired_handle;
		logic        event_retired;
		logic        created;
		logic        table_full;
	} result_t;

endpackage

[rtl/ptes_front.sv]
// Front end: accepts input beats, classifies them and holds them in a short queue.
// Depends on ptes_pkg.
module ptes_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               command,
	input  logic [31:0]        now_ms,
	input  logic [15:0]        event_handle,
	input  logic [31:0]        interval_ms,
	input  logic signed [15:0] repeat_count,
	input  logic signed [15:0] priority_req,
	output logic               q_valid,
	input  logic               q_pop,
	output ptes_pkg::item_t    q_item
);
	import ptes_pkg::*;

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	item_t              entry;
	logic               push;
	logic               pop;

	always_comb begin
		entry.now_ms       = now_ms;
		entry.event_handle = event_handle;
		entry.interval_ms  = interval_ms;
		entry.repeat_count = repeat_count;
		entry.priority_req = priority_req;
		if (command == CMD_TICK) begin
			entry.kind = KIND_TICK;
		end else if (repeat_count != 16'sd0) begin
			entry.kind = KIND_CREATE;
		end else begin
			entry.kind = KIND_NOP;
		end
	end

	assign item_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push       = item_valid && item_ready;
	assign q_valid    = (count_q != '0);
	assign pop        = q_pop && q_valid;
	assign q_item     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/ptes_back.sv]
// Back end: slot table, one-slot-per-cycle scan, update and result register.
// Depends on ptes_pkg; fed by ptes_front.
module ptes_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_pop,
	input  ptes_pkg::item_t  q_item,
	output logic             result_valid,
	input  logic             result_ready,
	output ptes_pkg::result_t result
);
	import ptes_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t             state_q;
	logic [SLOT_W-1:0]  idx_q;
	logic               valid_q [EVENT_SLOTS];
	logic [31:0]        due_q [EVENT_SLOTS];
	logic [31:0]        period_q [EVENT_SLOTS];
	logic signed [15:0] rem_q [EVENT_SLOTS];
	logic signed [15:0] prio_q [EVENT_SLOTS];
	logic [15:0]        handle_q [EVENT_SLOTS];
	logic [31:0]        stamp_q [EVENT_SLOTS];
	logic [31:0]        ctr_q;

	logic               have_q;
	logic [SLOT_W-1:0]  best_idx_q;
	logic signed [15:0] best_prio_q;
	logic [31:0]        best_due_q;
	logic [31:0]        best_stamp_q;
	logic signed [15:0] best_rem_q;
	logic [31:0]        best_period_q;
	logic [15:0]        best_handle_q;

	logic               out_valid_q;
	result_t            out_q;

	logic               take;
	logic [31:0]        age_c;
	logic [31:0]        age_b;
	logic               is_tick;
	logic               is_create;
	logic               rem_gt1;
	logic               retire;
	logic               commit;
	logic               last;
	result_t            res;

	assign is_tick   = (q_item.kind == KIND_TICK);
	assign is_create = (q_item.kind == KIND_CREATE);
	assign age_c     = ctr_q - stamp_q[idx_q];
	assign age_b     = ctr_q - best_stamp_q;
	assign last      = (idx_q == SLOT_W'(EVENT_SLOTS - 1));

	always_comb begin
		take = 1'b0;
		if (is_tick) begin
			if (valid_q[idx_q] && (due_q[idx_q] <= q_item.now_ms)) begin
				if (!have_q) begin
					take = 1'b1;
				end else if (prio_q[idx_q] != best_prio_q) begin
					take = prio_q[idx_q] > best_prio_q;
				end else if (due_q[idx_q] != best_due_q) begin
					take = due_q[idx_q] < best_due_q;
				end else begin
					take = age_c > age_b;
				end
			end
		end else if (is_create) begin
			take = !valid_q[idx_q] && !have_q;
		end
	end

	assign rem_gt1 = (best_rem_q > 16'sd1);
	assign retire  = have_q && is_tick && !rem_gt1 && !best_rem_q[15];
	assign commit  = (state_q == S_UPD) && (!out_valid_q || result_ready);
	assign q_pop   = commit;

	always_comb begin
		res.fired         = have_q && is_tick;
		res.fired_handle  = (have_q && is_tick) ? best_handle_q : 16'd0;
		res.event_retired = retire;
		res.created       = have_q && is_create;
		res.table_full    = !have_q && is_create;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			have_q      <= 1'b0;
			ctr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < EVENT_SLOTS; k++) begin
				valid_q[k] <= 1'b0;
			end
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_SCAN;
						idx_q   <= '0;
						have_q  <= 1'b0;
					end
				end
				S_SCAN: begin
					if (take) begin
						have_q <= 1'b1;
					end
					if (last) begin
						state_q <= S_UPD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_UPD: begin
					if (commit) begin
						state_q     <= S_IDLE;
						if (have_q && is_create) begin
							valid_q[best_idx_q] <= 1'b1;
						end
						if (retire) begin
							valid_q[best_idx_q] <= 1'b0;
						end
						if (have_q && (is_create || !retire)) begin
							ctr_q <= ctr_q + 32'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && take) begin
			best_idx_q    <= idx_q;
			best_prio_q   <= prio_q[idx_q];
			best_due_q    <= due_q[idx_q];
			best_stamp_q  <= stamp_q[idx_q];
			best_rem_q    <= rem_q[idx_q];
			best_period_q <= period_q[idx_q];
			best_handle_q <= handle_q[idx_q];
		end
		if (commit) begin
			out_q <= res;
			if (have_q && is_tick && !retire) begin
				due_q[best_idx_q]   <= q_item.now_ms + best_period_q;
				stamp_q[best_idx_q] <= ctr_q;
				if (rem_gt1) begin
					rem_q[best_idx_q] <= best_rem_q - 16'sd1;
				end
			end
			if (have_q && is_create) begin
				handle_q[best_idx_q] <= q_item.event_handle;
				period_q[best_idx_q] <= q_item.interval_ms;
				due_q[best_idx_q]    <= q_item.now_ms + q_item.interval_ms;
				rem_q[best_idx_q]    <= q_item.repeat_count;
				prio_q[best_idx_q]   <= q_item.priority_req;
				stamp_q[best_idx_q]  <= ctr_q;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef SYNTHESIS
	a_ctr_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctr_q != $past(ctr_q)) |-> $past(commit))
		else $error("stamp counter moved without an update");
	a_pop_only_upd: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == S_UPD) && q_valid)
		else $error("queue popped outside update");
	a_retire_fired: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.event_retired) |-> result.fired)
		else $error("retired without firing");
	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !((result.fired || result.event_retired)
			&& (result.created || result.table_full)))
		else $error("tick and create results mixed");
`endif

endmodule

[rtl/priority_timer_event_scheduler.sv]
// Top level of the priority timer event scheduler.
// Depends on ptes_pkg, ptes_front and ptes_back.
//
// Input channel item_valid/item_ready carries one command beat: a create
// (command 0) or a tick (command 1) with the current millisecond time.
// Output channel result_valid/result_ready returns exactly one result beat
// per input beat, in order.
// The front end queues up to two beats, so input is taken while the back end
// works or while a result waits. The back end scans the slot table one slot
// per cycle: an item passes a start step, a scan of all EVENT_SLOTS slots
// and an update step; the back end works on one item at a time.
// When the receiver stalls, the result is held in the output register, the
// back end waits in its update step and the queue fills, then item_ready
// falls. Reset clears all slots, queue, stamp counter and output valid.
module priority_timer_event_scheduler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               command,
	input  logic [31:0]        now_ms,
	input  logic [15:0]        event_handle,
	input  logic [31:0]        interval_ms,
	input  logic signed [15:0] repeat_count,
	input  logic signed [15:0] priority_req,
	output logic               result_valid,
	input  logic               result_ready,
	output logic               fired,
	output logic [15:0]        fired_handle,
	output logic               event_retired,
	output logic               created,
	output logic               table_full
);
	import ptes_pkg::*;

	logic    q_valid;
	logic    q_pop;
	item_t   q_item;
	result_t res;

	ptes_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.command      (command),
		.now_ms       (now_ms),
		.event_handle (event_handle),
		.interval_ms  (interval_ms),
		.repeat_count (repeat_count),
		.priority_req (priority_req),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_item       (q_item)
	);

	ptes_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_item       (q_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (res)
	);

	assign fired         = res.fired;
	assign fired_handle  = res.fired_handle;
	assign event_retired = res.event_retired;
	assign created       = res.created;
	assign table_full    = res.table_full;

endmodule

[tb/priority_timer_event_scheduler_tb.sv]
// Self-checking testbench of the priority timer event scheduler.
// Drives create and tick beats, predicts every result in a scoreboard class;
// depends on ptes_pkg and the priority_timer_event_scheduler top level.
`timescale 1ns / 100ps

module priority_timer_event_scheduler_tb;
	import ptes_pkg::*;

	localparam int LIMIT_CYCLES = 600000;

	typedef struct {
		logic        fired;
		logic [15:0] fired_handle;
		logic        event_retired;
		logic        created;
		logic        table_full;
	} outcome_t;

	class timer_table_board;
		bit                 valid_q [EVENT_SLOTS];
		logic [31:0]        due_q [EVENT_SLOTS];
		logic [31:0]        period_q [EVENT_SLOTS];
		logic signed [15:0] left_q [EVENT_SLOTS];
		logic signed [15:0] prio_q [EVENT_SLOTS];
		logic [15:0]        handle_q [EVENT_SLOTS];
		logic [31:0]        stamp_q [EVENT_SLOTS];
		logic [31:0]        next_stamp;
		outcome_t           pending[$];
		int                 errors;

		function new();
			foreach (valid_q[k]) valid_q[k] = 0;
			next_stamp = 0;
			errors = 0;
		endfunction

		function bit outranks(int a, int b);
			logic [31:0] age_a, age_b;
			if (prio_q[a] != prio_q[b])
				return prio_q[a] > prio_q[b];
			if (due_q[a] != due_q[b])
				return due_q[a] < due_q[b];
			age_a = next_stamp - stamp_q[a];
			age_b = next_stamp - stamp_q[b];
			return age_a > age_b;
		endfunction

		function void note_beat(logic cmd, logic [31:0] now, logic [15:0] hnd,
				logic [31:0] ivl, logic signed [15:0] rep, logic signed [15:0] pri);
			outcome_t o;
			int pick;
			o = '{default: 0};
			pick = -1;
			if (cmd == CMD_CREATE) begin
				if (rep != 0) begin
					for (int k = 0; k < EVENT_SLOTS; k++)
						if (!valid_q[k] && pick < 0) pick = k;
					if (pick < 0) begin
						o.table_full = 1;
					end else begin
						valid_q[pick] = 1;
						handle_q[pick] = hnd;
						period_q[pick] = ivl;
						due_q[pick] = now + ivl;
						left_q[pick] = rep;
						prio_q[pick] = pri;
						stamp_q[pick] = next_stamp++;
						o.created = 1;
					end
				end
			end else begin
				for (int k = 0; k < EVENT_SLOTS; k++)
					if (valid_q[k] && due_q[k] <= now)
						if (pick < 0 || outranks(k, pick)) pick = k;
				if (pick >= 0) begin
					o.fired = 1;
					o.fired_handle = handle_q[pick];
					if (left_q[pick] > 1) begin
						left_q[pick] = left_q[pick] - 1;
					end else if (left_q[pick] >= 0) begin
						left_q[pick] = 0;
						valid_q[pick] = 0;
						o.event_retired = 1;
					end
					if (!o.event_retired) begin
						due_q[pick] = now + period_q[pick];
						stamp_q[pick] = next_stamp++;
					end
				end
			end
			pending.push_back(o);
		endfunction

		function void check_beat(outcome_t got);
			outcome_t w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat", $time);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.fired !== w.fired) begin
				$display("%0t: fired exp %0d got %0d", $time, w.fired, got.fired);
				errors++;
			end
			if (got.fired_handle !== w.fired_handle) begin
				$display("%0t: fired_handle exp %0h got %0h", $time, w.fired_handle,
					got.fired_handle);
				errors++;
			end
			if (got.event_retired !== w.event_retired) begin
				$display("%0t: event_retired exp %0d got %0d", $time, w.event_retired,
					got.event_retired);
				errors++;
			end
			if (got.created !== w.created) begin
				$display("%0t: created exp %0d got %0d", $time, w.created, got.created);
				errors++;
			end
			if (got.table_full !== w.table_full) begin
				$display("%0t: table_full exp %0d got %0d", $time, w.table_full,
					got.table_full);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	logic               command;
	logic [31:0]        now_ms;
	logic [15:0]        event_handle;
	logic [31:0]        interval_ms;
	logic signed [15:0] repeat_count;
	logic signed [15:0] priority_req;
	logic               result_valid;
	logic               result_ready;
	logic               fired;
	logic [15:0]        fired_handle;
	logic               event_retired;
	logic               created;
	logic               table_full;

	timer_table_board board;
	logic [31:0] clock_ms;
	int          cycles;
	bit          hold_off;

	priority_timer_event_scheduler dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic int short_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	task automatic send_beat(logic cmd, logic [31:0] now, logic [15:0] hnd,
			logic [31:0] ivl, logic signed [15:0] rep, logic signed [15:0] pri);
		item_valid   <= 1;
		command      <= cmd;
		now_ms       <= now;
		event_handle <= hnd;
		interval_ms  <= ivl;
		repeat_count <= rep;
		priority_req <= pri;
		do @(posedge clk); while (!item_ready);
		board.note_beat(cmd, now, hnd, ivl, rep, pri);
	endtask

	task automatic idle_for(int n);
		if (n > 0) begin
			item_valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_create(logic [31:0] ivl, logic signed [15:0] rep,
			logic signed [15:0] pri);
		send_beat(CMD_CREATE, clock_ms, 16'($urandom), ivl, rep, pri);
	endtask

	task automatic send_tick(int step);
		clock_ms = clock_ms + step;
		send_beat(CMD_TICK, clock_ms, 16'($urandom), $urandom, 16'($urandom),
			16'($urandom));
	endtask

	// receiver: random stalls, and one long hold-off
	initial begin
		result_ready <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) result_ready <= 0;
			else result_ready <= ($urandom_range(0, 3) != 0) ||
				($urandom_range(0, 1) == 0 && cycles % 500 < 200);
		end
	end

	always @(posedge clk) begin
		outcome_t got;
		if (arst_n && result_valid && result_ready) begin
			got.fired = fired;
			got.fired_handle = fired_handle;
			got.event_retired = event_retired;
			got.created = created;
			got.table_full = table_full;
			board.check_beat(got);
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("priority_timer_event_scheduler regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int kind;
		board = new();
		hold_off = 0;
		clock_ms = 0;
		arst_n = 0;
		item_valid = 0;
		command = CMD_CREATE;
		now_ms = 0;
		event_handle = 0;
		interval_ms = 0;
		repeat_count = 0;
		priority_req = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, zero repeat, full table, nothing due, ties
		send_tick(0);
		send_create(0, 0, 0);
		send_beat(CMD_CREATE, 32'hFFFF_FFF0, 16'hFFFF, 32'hFFFF_FFFF, 16'sh7FFF,
			16'sh7FFF);
		send_beat(CMD_CREATE, 0, 16'h0000, 0, -16'sd32768, -16'sd32768);
		send_create(5, 1, 3);
		send_create(5, 2, 3);
		send_create(5, -1, 3);
		send_tick(4);
		send_tick(1);
		send_tick(0);
		send_tick(0);
		send_tick(10);
		send_tick(0);
		for (int i = 0; i < 14; i++) send_create($urandom_range(0, 3), 1, 16'($urandom));
		send_tick(0);
		send_tick(5);
		for (int i = 0; i < 6; i++) send_tick(1);
		hold_off = 1;
		// long hold-off while the sender keeps offering
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 6; i++) send_tick(2);
		join
		for (int i = 0; i < 20; i++) send_tick(100);

		for (int i = 0; i < 1500; i++) begin
			idle_for(short_gap());
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				send_create($urandom_range(0, 20),
					($urandom_range(0, 4) == 0) ? -16'sd1 :
					16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)) - 16'sd1);
			end else if (kind < 45) begin
				send_beat(CMD_CREATE, $urandom, $urandom, $urandom, 16'($urandom),
					16'($urandom));
			end else if (kind < 95) begin
				send_tick($urandom_range(0, 6));
			end else begin
				clock_ms = $urandom;
				send_tick(0);
			end
		end
		clock_ms = 32'hFFFF_FFFF;
		for (int i = 0; i < 40; i++) send_tick(0);
		item_valid <= 0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0)
			$display("priority_timer_event_scheduler regression: pass");
		else
			$display("priority_timer_event_scheduler regression: fail");
		$finish;
	end

endmodule
